### src/tvm_pkg.sv
// ----------------------------------------------------------------------------
// tvm_pkg
// Shared types, constants and the microcode program of the temperature and
// supply monitor.
// ----------------------------------------------------------------------------
package tvm_pkg;

	// design defaults
	localparam int AVG_LOG2_DEF    = 2;
	localparam int SAMPLE_BITS_DEF = 12;

	// register reset values
	localparam logic [11:0]        CAL_LOW_RST  = 12'd1040;
	localparam logic [11:0]        CAL_HIGH_RST = 12'd1380;
	localparam logic [11:0]        VREF_RST     = 12'd1501;
	localparam logic signed [15:0] UPPER_RST    = 16'sd850;
	localparam logic signed [15:0] LOWER_RST    = -16'sd400;
	localparam logic [15:0]        SUPPLY_RST   = 16'd330;

	// arithmetic constants
	localparam logic [15:0] TEMP_OFFSET = 16'd300;
	localparam int          SUPPLY_NOM  = 330;

	// configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 40;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CAL_LOW  = 3'd0,
		REG_CAL_HIGH = 3'd1,
		REG_VREF     = 3'd2,
		REG_UPPER    = 3'd3,
		REG_LOWER    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        cal_low;
		logic [11:0]        cal_high;
		logic [11:0]        vref;
		logic signed [15:0] upper;
		logic signed [15:0] lower;
	} cfg_t;

	// sample kinds
	localparam logic CMD_TEMP = 1'b0;
	localparam logic CMD_REF  = 1'b1;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP      = 4'd0,
		OP_REF_DIV  = 4'd1,
		OP_SUPPLY   = 4'd2,
		OP_MUL      = 4'd3,
		OP_COMP     = 4'd4,
		OP_SCALE    = 4'd5,
		OP_CAL_DIV  = 4'd6,
		OP_ACCUM    = 4'd7,
		OP_AVG      = 4'd8,
		OP_OUT      = 4'd9
	} op_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER    = 4'd0,
		C_ALWAYS   = 4'd1,
		C_NO_IN    = 4'd2,
		C_IS_TEMP  = 4'd3,
		C_SMP_ZERO = 4'd4,
		C_DIV_BUSY = 4'd5,
		C_DEN_ZERO = 4'd6,
		C_CNT_PART = 4'd7,
		C_OUT_BUSY = 4'd8
	} cond_t;

	localparam int PC_W = 4;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic is_temp;
		logic smp_zero;
		logic den_zero;
		logic cnt_part;
	} dp_stat_t;

	// program steps
	localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] ST_DISPATCH = 4'd1;
	localparam logic [PC_W-1:0] ST_REF_DIV  = 4'd2;
	localparam logic [PC_W-1:0] ST_REF_WAIT = 4'd3;
	localparam logic [PC_W-1:0] ST_SUPPLY   = 4'd4;
	localparam logic [PC_W-1:0] ST_MUL      = 4'd5;
	localparam logic [PC_W-1:0] ST_COMP     = 4'd6;
	localparam logic [PC_W-1:0] ST_SCALE    = 4'd7;
	localparam logic [PC_W-1:0] ST_CAL_DIV  = 4'd8;
	localparam logic [PC_W-1:0] ST_CAL_WT   = 4'd9;
	localparam logic [PC_W-1:0] ST_ACCUM    = 4'd10;
	localparam logic [PC_W-1:0] ST_AVG      = 4'd11;
	localparam logic [PC_W-1:0] ST_OUT      = 4'd12;
	localparam logic [PC_W-1:0] ST_RETURN   = 4'd13;

	// control store: jump to target when the condition holds, else step on
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
		case (pc)
			ST_IDLE:     w = '{op: OP_NOP,      cond: C_NO_IN,    target: ST_IDLE};
			ST_DISPATCH: w = '{op: OP_NOP,      cond: C_IS_TEMP,  target: ST_MUL};
			ST_REF_DIV:  w = '{op: OP_REF_DIV,  cond: C_SMP_ZERO, target: ST_OUT};
			ST_REF_WAIT: w = '{op: OP_NOP,      cond: C_DIV_BUSY, target: ST_REF_WAIT};
			ST_SUPPLY:   w = '{op: OP_SUPPLY,   cond: C_ALWAYS,   target: ST_OUT};
			ST_MUL:      w = '{op: OP_MUL,      cond: C_NEVER,    target: ST_IDLE};
			ST_COMP:     w = '{op: OP_COMP,     cond: C_NEVER,    target: ST_IDLE};
			ST_SCALE:    w = '{op: OP_SCALE,    cond: C_NEVER,    target: ST_IDLE};
			ST_CAL_DIV:  w = '{op: OP_CAL_DIV,  cond: C_DEN_ZERO, target: ST_ACCUM};
			ST_CAL_WT:   w = '{op: OP_NOP,      cond: C_DIV_BUSY, target: ST_CAL_WT};
			ST_ACCUM:    w = '{op: OP_ACCUM,    cond: C_CNT_PART, target: ST_OUT};
			ST_AVG:      w = '{op: OP_AVG,      cond: C_NEVER,    target: ST_IDLE};
			ST_OUT:      w = '{op: OP_OUT,      cond: C_OUT_BUSY, target: ST_OUT};
			ST_RETURN:   w = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_IDLE};
			default:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

### src/tvm_div.sv
// ----------------------------------------------------------------------------
// tvm_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module tvm_div #(
	parameter int DW = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;

	assign trial    = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};
	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			// keep the partial remainder when the trial subtract borrows
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
			end
			quo_q <= {quo_q[DW-2:0], ~trial[DW]};
		end
	end

endmodule

### src/tvm_seq.sv
// ----------------------------------------------------------------------------
// tvm_seq
// Microcode sequencer: step counter, control store and jump conditions.
// ----------------------------------------------------------------------------
module tvm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tvm_pkg::dp_stat_t dstat,
	input  logic              div_busy,
	input  logic              out_busy,
	output logic              in_ready,
	output tvm_pkg::op_t      op
);

	logic [tvm_pkg::PC_W-1:0] pc_q;
	tvm_pkg::ucode_t          uw;
	logic                     take;

	assign uw       = tvm_pkg::ucode_rom(pc_q);
	assign op       = uw.op;
	assign in_ready = (pc_q == tvm_pkg::ST_IDLE);

	always_comb begin
		unique case (uw.cond)
			tvm_pkg::C_NEVER:    take = 1'b0;
			tvm_pkg::C_ALWAYS:   take = 1'b1;
			tvm_pkg::C_NO_IN:    take = !in_valid;
			tvm_pkg::C_IS_TEMP:  take = dstat.is_temp;
			tvm_pkg::C_SMP_ZERO: take = dstat.smp_zero;
			tvm_pkg::C_DIV_BUSY: take = div_busy;
			tvm_pkg::C_DEN_ZERO: take = dstat.den_zero;
			tvm_pkg::C_CNT_PART: take = dstat.cnt_part;
			tvm_pkg::C_OUT_BUSY: take = out_busy;
			default:             take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= tvm_pkg::ST_IDLE;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

### src/tvm_dpath.sv
// ----------------------------------------------------------------------------
// tvm_dpath
// Datapath: sample latch, supply store, scaling, calibration, averaging and
// warning flag, with operand selection for the shared divider.
// ----------------------------------------------------------------------------
module tvm_dpath #(
	parameter int AVG_LOG2    = tvm_pkg::AVG_LOG2_DEF,
	parameter int SAMPLE_BITS = tvm_pkg::SAMPLE_BITS_DEF,
	parameter int DW          = SAMPLE_BITS + 19
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tvm_pkg::op_t           op,
	input  tvm_pkg::cfg_t          cfg,
	input  logic                   in_accept,
	input  logic                   in_cmd,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic [DW-1:0]          div_quot,
	output logic                   div_start,
	output logic [DW-1:0]          div_dividend,
	output logic [DW-1:0]          div_divisor,
	output tvm_pkg::dp_stat_t      dstat,
	output logic signed [15:0]     temperature,
	output logic                   temp_updated,
	output logic [15:0]            supply_level,
	output logic                   temp_warning
);

	localparam int PROD_W = SAMPLE_BITS + 16;
	localparam int COMP_W = PROD_W - 8;
	localparam int NUM_W  = COMP_W + 11;
	localparam int SUM_W  = 16 + AVG_LOG2;
	localparam int CNT_W  = (AVG_LOG2 > 0) ? AVG_LOG2 : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((1 << AVG_LOG2) - 1);
	localparam int REC_SH = PROD_W + $clog2(tvm_pkg::SUPPLY_NOM);
	localparam logic [PROD_W:0] REC_MUL = (PROD_W + 1)'(((64'd1 << REC_SH)
		+ 64'(tvm_pkg::SUPPLY_NOM) - 64'd1) / 64'(tvm_pkg::SUPPLY_NOM));

	logic                   cmd_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [15:0]            supply_q;
	logic [PROD_W-1:0]      prod_q;
	logic [COMP_W-1:0]      comp_q;
	logic [NUM_W-1:0]       num_q;
	logic                   neg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [15:0]     temp_q;
	logic                   upd_q;
	logic                   warn_q;

	logic [DW-1:0]          vref_x;
	logic [DW-1:0]          vref330;
	logic [PROD_W-1:0]      prod_d;
	logic [2*PROD_W:0]      rec_prod;
	logic [COMP_W:0]        diff;
	logic [NUM_W-1:0]       diff_x;
	logic [NUM_W-1:0]       num_d;
	logic [NUM_W-1:0]       num_mag;
	logic signed [12:0]     den;
	logic [12:0]            den_mag;
	logic [15:0]            q16;
	logic [15:0]            q_sel;
	logic signed [15:0]     val;
	logic signed [SUM_W-1:0] sum_d;
	logic signed [SUM_W-1:0] sum_sh;
	logic signed [15:0]     avg;

	// vref_cal * 330 as shifts and adds
	assign vref_x  = DW'(cfg.vref);
	assign vref330 = (vref_x << 8) + (vref_x << 6) + (vref_x << 3) + (vref_x << 1);

	assign prod_d = PROD_W'(sample_q) * PROD_W'(supply_q);

	// product / 330 by reciprocal multiplication, exact over the product range
	assign rec_prod = (2*PROD_W + 1)'(prod_q) * (2*PROD_W + 1)'(REC_MUL);

	// 800 * (comp - cal_low)
	assign diff    = {1'b0, comp_q} - (COMP_W + 1)'(cfg.cal_low);
	assign diff_x  = {{(NUM_W - COMP_W - 1){diff[COMP_W]}}, diff};
	assign num_d   = (diff_x << 9) + (diff_x << 8) + (diff_x << 5);
	assign num_mag = num_q[NUM_W-1] ? (~num_q + 1'b1) : num_q;

	assign den     = $signed({1'b0, cfg.cal_high}) - $signed({1'b0, cfg.cal_low});
	assign den_mag = den[12] ? (~den + 1'b1) : den;

	// low 16 bits of the truncated signed quotient, plus offset
	assign q16   = div_quot[15:0];
	assign q_sel = dstat.den_zero ? 16'd0 : (neg_q ? (~q16 + 16'd1) : q16);
	assign val   = $signed(q_sel + tvm_pkg::TEMP_OFFSET);
	assign sum_d = sum_q + SUM_W'(val);

	assign sum_sh = sum_q >>> AVG_LOG2;
	assign avg    = sum_sh[15:0];

	assign dstat.is_temp  = (cmd_q == tvm_pkg::CMD_TEMP);
	assign dstat.smp_zero = (sample_q == '0);
	assign dstat.den_zero = (cfg.cal_high == cfg.cal_low);
	assign dstat.cnt_part = (cnt_q != CNT_MAX);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		case (op)
			tvm_pkg::OP_REF_DIV: begin
				div_start    = !dstat.smp_zero;
				div_dividend = vref330;
				div_divisor  = DW'(sample_q);
			end
			tvm_pkg::OP_CAL_DIV: begin
				div_start    = !dstat.den_zero;
				div_dividend = DW'(num_mag);
				div_divisor  = DW'(den_mag);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// payload of the current item and its intermediate results
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q    <= in_cmd;
			sample_q <= in_sample;
		end
		if (op == tvm_pkg::OP_MUL) begin
			prod_q <= prod_d;
		end
		if (op == tvm_pkg::OP_COMP) begin
			comp_q <= rec_prod[REC_SH +: COMP_W];
		end
		if (op == tvm_pkg::OP_SCALE) begin
			num_q <= num_d;
		end
		if (op == tvm_pkg::OP_CAL_DIV) begin
			neg_q <= num_q[NUM_W-1] ^ den[12];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= tvm_pkg::SUPPLY_RST;
			sum_q    <= '0;
			cnt_q    <= '0;
			temp_q   <= '0;
			upd_q    <= 1'b0;
			warn_q   <= 1'b0;
		end else begin
			case (op)
				tvm_pkg::OP_REF_DIV: begin
					if (dstat.smp_zero) begin
						supply_q <= '0;
					end
				end
				tvm_pkg::OP_SUPPLY: begin
					supply_q <= div_quot[15:0];
				end
				tvm_pkg::OP_ACCUM: begin
					sum_q <= sum_d;
					cnt_q <= dstat.cnt_part ? cnt_q + 1'b1 : '0;
				end
				tvm_pkg::OP_AVG: begin
					temp_q <= avg;
					upd_q  <= 1'b1;
					sum_q  <= '0;
					if (avg > cfg.upper || avg < cfg.lower) begin
						warn_q <= 1'b1;
					end
				end
				default: begin
					upd_q <= upd_q & !in_accept;
				end
			endcase
		end
	end

	assign temperature  = temp_q;
	assign temp_updated = upd_q;
	assign supply_level = supply_q;
	assign temp_warning = warn_q;

endmodule

### src/temp_vdd_monitor_top.sv
// ----------------------------------------------------------------------------
// temp_vdd_monitor_top
// Temperature and supply monitor with calibration registers and result stage.
// ----------------------------------------------------------------------------
// Each input item is one converter sample, tagged in s_tuser as a temperature
// reading (0) or an internal reference reading (1); each item yields exactly
// one result item. A reference item recomputes the supply estimate
// (vref_cal*330/sample, 100 counts per volt); a temperature item is scaled by
// supply/330, mapped through the two-point calibration to tenths of a degree,
// and every 2^AVG_LOG2 such values are averaged, published and checked against
// the limits (the warning is sticky until reset). The block handles one item
// at a time under a microcoded sequencer. The division by 330 is a reciprocal
// multiplication; the divisions by the reference sample and by the
// calibration span share one restoring divider of DW = SAMPLE_BITS+19 bits,
// one quotient bit per cycle. A zero reference sample skips the divider and
// sets the supply estimate to zero; with the two calibration points equal, a
// temperature item skips the divider and its quotient counts as zero. The
// item that completes an average passes through an extra averaging step.
// A result waiting in the output register does not block acceptance of the
// next item; the next result then holds the sequencer in its output step
// until the register is taken. Configuration writes are taken at any edge
// with cfg_we high, but belong in idle periods.
// ----------------------------------------------------------------------------
module temp_vdd_monitor_top #(
	parameter int AVG_LOG2    = tvm_pkg::AVG_LOG2_DEF,
	parameter int SAMPLE_BITS = tvm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [SAMPLE_BITS-1:0] sample, zero padding above
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	// [0] command
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [15:0] temperature, [16] temp_updated, [32:17] supply_level,
	// [33] temp_warning, zero padding above
	output logic [tvm_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           cfg_we,
	input  logic [tvm_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tvm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DW = SAMPLE_BITS + 19;

	tvm_pkg::cfg_t     cfg_q;
	tvm_pkg::op_t      op;
	tvm_pkg::dp_stat_t dstat;

	logic                     in_accept;
	logic                     div_start;
	logic                     div_busy;
	logic [DW-1:0]            div_dividend;
	logic [DW-1:0]            div_divisor;
	logic [DW-1:0]            div_quot;
	logic signed [15:0]       temperature;
	logic                     temp_updated;
	logic [15:0]              supply_level;
	logic                     temp_warning;
	logic                     out_busy;
	logic                     out_load;
	logic                     out_valid_q;
	logic [tvm_pkg::OUT_W-1:0] out_data_q;

	assign in_accept = s_tvalid && s_tready;
	assign out_busy  = out_valid_q && !m_tready;
	assign out_load  = (op == tvm_pkg::OP_OUT) && !out_busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_low  <= tvm_pkg::CAL_LOW_RST;
			cfg_q.cal_high <= tvm_pkg::CAL_HIGH_RST;
			cfg_q.vref     <= tvm_pkg::VREF_RST;
			cfg_q.upper    <= tvm_pkg::UPPER_RST;
			cfg_q.lower    <= tvm_pkg::LOWER_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tvm_pkg::REG_CAL_LOW:  cfg_q.cal_low  <= cfg_wdata[11:0];
				tvm_pkg::REG_CAL_HIGH: cfg_q.cal_high <= cfg_wdata[11:0];
				tvm_pkg::REG_VREF:     cfg_q.vref     <= cfg_wdata[11:0];
				tvm_pkg::REG_UPPER:    cfg_q.upper    <= $signed(cfg_wdata);
				tvm_pkg::REG_LOWER:    cfg_q.lower    <= $signed(cfg_wdata);
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	tvm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.dstat    (dstat),
		.div_busy (div_busy),
		.out_busy (out_busy),
		.in_ready (s_tready),
		.op       (op)
	);

	tvm_dpath #(
		.AVG_LOG2    (AVG_LOG2),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DW          (DW)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.cfg          (cfg_q),
		.in_accept    (in_accept),
		.in_cmd       (s_tuser),
		.in_sample    (s_tdata[SAMPLE_BITS-1:0]),
		.div_quot     (div_quot),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.dstat        (dstat),
		.temperature  (temperature),
		.temp_updated (temp_updated),
		.supply_level (supply_level),
		.temp_warning (temp_warning)
	);

	tvm_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, temp_warning, supply_level, temp_updated, temperature};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the temperature and supply monitor: a predictor
// tracks supply, running average and warning per sample, and each result
// item is compared field by field while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT   = 2000000;
	localparam int HOLD_CYCLES   = 500;
	localparam int PHASE_SAMPLES = 220;
	localparam int AVG_LEN       = 1 << tvm_pkg::AVG_LOG2_DEF;

	typedef struct packed {
		logic signed [15:0] temperature;
		logic               updated;
		logic [15:0]        supply;
		logic               warning;
	} reading_t;

	class reading_predictor;
		tvm_pkg::cfg_t      cfg;
		logic [15:0]        supply;
		logic signed [17:0] sum;
		int unsigned        count;
		logic signed [15:0] temp;
		logic               warn;
		reading_t           expected_readings[$];
		int                 fail_count;

		function new();
			cfg = '{cal_low: tvm_pkg::CAL_LOW_RST, cal_high: tvm_pkg::CAL_HIGH_RST,
				vref: tvm_pkg::VREF_RST, upper: tvm_pkg::UPPER_RST,
				lower: tvm_pkg::LOWER_RST};
			supply     = tvm_pkg::SUPPLY_RST;
			sum        = '0;
			count      = 0;
			temp       = '0;
			warn       = 1'b0;
			fail_count = 0;
		endfunction

		function void set_reg(tvm_pkg::reg_idx_t idx, logic [15:0] val);
			case (idx)
				tvm_pkg::REG_CAL_LOW:  cfg.cal_low  = val[11:0];
				tvm_pkg::REG_CAL_HIGH: cfg.cal_high = val[11:0];
				tvm_pkg::REG_VREF:     cfg.vref     = val[11:0];
				tvm_pkg::REG_UPPER:    cfg.upper    = val;
				tvm_pkg::REG_LOWER:    cfg.lower    = val;
				default: ;
			endcase
		endfunction

		// supply compensation, then two-point map to tenths of a degree
		function logic signed [15:0] calibrate(logic [11:0] raw);
			longint      comp;
			longint      span;
			longint      num;
			longint      quo;
			logic [63:0] wide;
			comp = (longint'(raw) * longint'(supply)) / 330;
			span = longint'(cfg.cal_high) - longint'(cfg.cal_low);
			num  = 800 * (comp - longint'(cfg.cal_low));
			quo  = (span == 0) ? 0 : num / span;
			wide = quo + 300;
			return wide[15:0];
		endfunction

		function void take_sample(logic cmd, logic [11:0] smp);
			reading_t           r;
			logic signed [17:0] shifted;
			logic signed [15:0] avg;
			logic [31:0]        quo;
			r.updated = 1'b0;
			if (cmd == tvm_pkg::CMD_REF) begin
				quo    = (smp == 0) ? 32'd0 : (32'(cfg.vref) * 32'd330) / 32'(smp);
				supply = quo[15:0];
			end else begin
				sum = sum + calibrate(smp);
				count++;
				if (count >= AVG_LEN) begin
					shifted = sum >>> tvm_pkg::AVG_LOG2_DEF;
					avg     = shifted[15:0];
					temp    = avg;
					if (avg > $signed(cfg.upper) || avg < $signed(cfg.lower))
						warn = 1'b1;
					sum       = '0;
					count     = 0;
					r.updated = 1'b1;
				end
			end
			r.temperature = temp;
			r.supply      = supply;
			r.warning     = warn;
			expected_readings.push_back(r);
		endfunction

		function void check_reading(logic [tvm_pkg::OUT_W-1:0] data);
			reading_t exp_r;
			if (expected_readings.size() == 0) begin
				$error("unexpected result item %h", data);
				fail_count++;
				return;
			end
			exp_r = expected_readings.pop_front();
			if (data[15:0] !== exp_r.temperature) begin
				$error("temperature: expected %0d, got %0d", exp_r.temperature,
					$signed(data[15:0]));
				fail_count++;
			end
			if (data[16] !== exp_r.updated) begin
				$error("temp_updated: expected %0d, got %0d", exp_r.updated, data[16]);
				fail_count++;
			end
			if (data[32:17] !== exp_r.supply) begin
				$error("supply_level: expected %0d, got %0d", exp_r.supply, data[32:17]);
				fail_count++;
			end
			if (data[33] !== exp_r.warning) begin
				$error("temp_warning: expected %0d, got %0d", exp_r.warning, data[33]);
				fail_count++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [15:0]                    s_tdata;
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [tvm_pkg::OUT_W-1:0]      m_tdata;
	logic                           cfg_we;
	logic [tvm_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [tvm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	reading_predictor model = new();
	bit               quiet;
	bit               hold_req;
	int               cycle_count;

	temp_vdd_monitor_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 90);
	endfunction

	// temperature samples cluster around the calibration window
	function automatic logic [11:0] pick_temp();
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 1) ? 4095 : 0;
			1, 2, 3: v = $urandom_range(0, 4095);
			default: v = int'(model.cfg.cal_low) + $urandom_range(0, 500) - 100;
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	function automatic logic [11:0] pick_ref();
		int v;
		case ($urandom_range(0, 19))
			0: v = 0;
			1, 2, 3: v = $urandom_range(0, 4095);
			default: v = int'(model.cfg.vref) + $urandom_range(0, 40) - 20;
		endcase
		if (v < 0)
			v = $urandom_range(1, 4095);
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	task automatic write_reg(tvm_pkg::reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		model.set_reg(idx, val);
	endtask

	task automatic program_regs(logic [11:0] lo, logic [11:0] hi, logic [11:0] vr,
			logic [15:0] up, logic [15:0] dn);
		write_reg(tvm_pkg::REG_CAL_LOW, {4'd0, lo});
		write_reg(tvm_pkg::REG_CAL_HIGH, {4'd0, hi});
		write_reg(tvm_pkg::REG_VREF, {4'd0, vr});
		write_reg(tvm_pkg::REG_UPPER, up);
		write_reg(tvm_pkg::REG_LOWER, dn);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(logic cmd, logic [11:0] smp);
		int gap;
		gap = idle_len();
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'd0, smp};
		do
			@(posedge clk);
		while (!s_tready);
		model.take_sample(cmd, smp);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (model.expected_readings.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int n, bit with_hold);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (with_hold && i == 60)
				hold_req = 1'b1;
			if ($urandom_range(0, 4) == 0)
				send_sample(tvm_pkg::CMD_REF, pick_ref());
			else
				send_sample(tvm_pkg::CMD_TEMP, pick_temp());
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 15) begin
				stall_left = idle_len();
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.check_reading(m_tdata);
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// both limits at the exact average of four samples at the low point
		program_regs(tvm_pkg::CAL_LOW_RST, tvm_pkg::CAL_HIGH_RST, tvm_pkg::VREF_RST,
			16'd300, 16'd300);
		send_sample(tvm_pkg::CMD_REF, 12'd1501);
		repeat (4) send_sample(tvm_pkg::CMD_TEMP, 12'd1040);
		repeat (4) send_sample(tvm_pkg::CMD_TEMP, 12'd1041);
		// zero reference, then a tiny one whose quotient wraps
		send_sample(tvm_pkg::CMD_REF, 12'd0);
		send_sample(tvm_pkg::CMD_TEMP, 12'd4095);
		send_sample(tvm_pkg::CMD_TEMP, 12'd0);
		send_sample(tvm_pkg::CMD_REF, 12'd1);
		send_sample(tvm_pkg::CMD_TEMP, 12'd4095);
		send_sample(tvm_pkg::CMD_TEMP, 12'd4095);
		send_sample(tvm_pkg::CMD_REF, 12'd4095);
		send_sample(tvm_pkg::CMD_TEMP, 12'd0);
		send_sample(tvm_pkg::CMD_TEMP, 12'd0);
		send_sample(tvm_pkg::CMD_TEMP, 12'd2048);
		send_sample(tvm_pkg::CMD_TEMP, 12'd1);
		send_sample(tvm_pkg::CMD_REF, 12'd2048);
		send_sample(tvm_pkg::CMD_TEMP, 12'd1380);
		send_sample(tvm_pkg::CMD_TEMP, 12'd1380);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: program_regs(tvm_pkg::CAL_LOW_RST, tvm_pkg::CAL_HIGH_RST,
					tvm_pkg::VREF_RST, tvm_pkg::UPPER_RST, tvm_pkg::LOWER_RST);
				1: program_regs(12'd0, 12'd4095, 12'd4095, 16'h7FFF, 16'h8000);
				// negative calibration span, zero reference constant
				2: program_regs(12'd4095, 12'd0, 12'd0, 16'h8000, 16'h7FFF);
				// equal calibration points
				3: program_regs(12'd2000, 12'd2000, 12'd1200, 16'd0, 16'd0);
				4: program_regs(12'($urandom_range(800, 1200)),
					12'($urandom_range(1300, 1700)), 12'($urandom_range(1200, 1700)),
					16'($urandom_range(300, 1200)), 16'(-$urandom_range(0, 800)));
				default: program_regs(12'($urandom), 12'($urandom), 12'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			run_random(PHASE_SAMPLES, ph == 0);
			settle();
		end

		quiet = 1'b1;
		repeat (100) @(posedge clk);
		if (model.fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
src/tvm_pkg.sv
src/tvm_div.sv
src/tvm_seq.sv
src/tvm_dpath.sv
src/temp_vdd_monitor_top.sv
test/tb.sv
